// ===== rtl/core/imu_gbr_pkg.sv =====
package imu_gbr_pkg;

	localparam int CAL_SAMPLES = 2000;
	localparam int BURST_BYTES = 14;
	localparam int HELD_BYTES  = BURST_BYTES - 1;
	localparam int NUM_WORDS   = BURST_BYTES / 2;
	localparam int POS_W       = $clog2(BURST_BYTES + 1);
	localparam int HIDX_W      = $clog2(HELD_BYTES);
	localparam int SUM_W       = 16 + $clog2(CAL_SAMPLES);
	localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
	localparam int RECIP_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
	localparam int RECIP_W     = SUM_W + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(
		((longint'(1) << RECIP_SHIFT) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES));
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		OP_BURST_START = 2'd0,
		OP_DATA        = 2'd1,
		OP_CAL_START   = 2'd2
	} opcode_t;

	typedef enum logic {
		CMD_FRAME,
		CMD_CAL_START
	} cmd_kind_t;

	typedef logic signed [15:0]      word_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		word_t [NUM_WORDS-1:0]     words;
	} cmd_t;

	typedef struct packed {
		word_t accel_x;
		word_t accel_y;
		word_t accel_z;
		word_t temperature;
		word_t rate_x;
		word_t rate_y;
		word_t rate_z;
		logic  is_calibrated;
		logic  in_calibration;
	} result_t;

endpackage

// ===== rtl/core/imu_gbr_in_if.sv =====
interface imu_gbr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;

	modport source(output valid, output opcode, output data_byte, input ready);
	modport sink(input valid, input opcode, input data_byte, output ready);
endinterface

// ===== rtl/core/imu_gbr_out_if.sv =====
interface imu_gbr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] temperature;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_y;
	logic signed [15:0] rate_z;
	logic               is_calibrated;
	logic               in_calibration;

	modport source(
		output valid, output accel_x, output accel_y, output accel_z, output temperature,
		output rate_x, output rate_y, output rate_z, output is_calibrated,
		output in_calibration, input ready
	);
	modport sink(
		input valid, input accel_x, input accel_y, input accel_z, input temperature,
		input rate_x, input rate_y, input rate_z, input is_calibrated,
		input in_calibration, output ready
	);
endinterface

// ===== rtl/core/imu_gbr_front.sv =====
module imu_gbr_front (
	input  logic               clk,
	input  logic               arst_n,
	imu_gbr_in_if.sink         burst,
	output logic               push,
	output imu_gbr_pkg::cmd_t  push_cmd,
	input  logic               full
);
	import imu_gbr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       held_q [HELD_BYTES];
	logic [7:0]       frame [BURST_BYTES];
	logic             accept;
	opcode_t          op;

	assign burst.ready = !full;
	assign accept      = burst.valid && burst.ready;
	assign op          = opcode_t'(burst.opcode);

	always_comb begin
		for (int i = 0; i < HELD_BYTES; i++) begin
			frame[i] = held_q[i];
		end
		frame[HELD_BYTES] = burst.data_byte;
	end

	always_comb begin
		push_cmd.kind = CMD_FRAME;
		for (int i = 0; i < NUM_WORDS; i++) begin
			push_cmd.words[i] = word_t'({frame[2*i], frame[2*i+1]});
		end
		push = 1'b0;
		unique case (op)
			OP_DATA: begin
				push = accept && (pos_q == POS_W'(HELD_BYTES));
			end
			OP_CAL_START: begin
				push          = accept;
				push_cmd.kind = CMD_CAL_START;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			unique case (op)
				OP_BURST_START: begin
					pos_q <= '0;
				end
				OP_DATA: begin
					if (pos_q < POS_W'(BURST_BYTES)) begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op == OP_DATA && pos_q < POS_W'(HELD_BYTES)) begin
			held_q[pos_q[HIDX_W-1:0]] <= burst.data_byte;
		end
	end

endmodule

// ===== rtl/core/imu_gbr_fifo.sv =====
module imu_gbr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  imu_gbr_pkg::cmd_t  push_cmd,
	output logic               full,
	input  logic               pop,
	output imu_gbr_pkg::cmd_t  pop_cmd,
	output logic               empty
);
	import imu_gbr_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/core/imu_gbr_div.sv =====
module imu_gbr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  imu_gbr_pkg::sum_t [2:0]   sums,
	output logic                      busy,
	output logic                      done,
	output imu_gbr_pkg::word_t [2:0]  quot
);
	import imu_gbr_pkg::*;

	logic [SUM_W-1:0]  mag_q [3];
	logic [PROD_W-1:0] prod_q [3];
	logic              neg_q [3];
	logic              busy_q;
	logic              done_q;
	logic [15:0]       quot_mag [3];

	assign busy = busy_q || done_q;
	assign done = done_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quot_mag[i] = prod_q[i][RECIP_SHIFT +: 16];
			quot[i]     = neg_q[i] ? word_t'(-quot_mag[i]) : word_t'(quot_mag[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (start) begin
				neg_q[i] <= sums[i][SUM_W-1];
				mag_q[i] <= sums[i][SUM_W-1] ? SUM_W'(-sums[i]) : SUM_W'(sums[i]);
			end else if (busy_q) begin
				prod_q[i] <= {{RECIP_W{1'b0}}, mag_q[i]} * {{SUM_W{1'b0}}, RECIP_MUL};
			end
		end
	end

endmodule

// ===== rtl/core/imu_gbr_back.sv =====
module imu_gbr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  imu_gbr_pkg::cmd_t  pop_cmd,
	input  logic               empty,
	output logic               pop,
	imu_gbr_out_if.source      sample
);
	import imu_gbr_pkg::*;

	sum_t [2:0]       sums_q;
	sum_t [2:0]       new_sums;
	word_t [2:0]      offsets_q;
	word_t [2:0]      quot;
	logic [CNT_W-1:0] count_q;
	logic             calibrating_q;
	logic             calibrated_q;
	logic             out_valid_q;
	result_t          result_q;
	logic             can_load;
	logic             last;
	logic             applied;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic             is_frame;

	imu_gbr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.sums  (new_sums),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (quot)
	);

	assign can_load  = !out_valid_q || sample.ready;
	assign is_frame  = (pop_cmd.kind == CMD_FRAME);
	assign pop       = !empty && !div_busy && (can_load || !is_frame);
	assign last      = (count_q == CNT_W'(CAL_SAMPLES - 1));
	assign applied   = calibrated_q && !calibrating_q;
	assign div_start = pop && is_frame && calibrating_q && last;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			new_sums[i] = sums_q[i] + sum_t'(pop_cmd.words[4+i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q        <= '0;
			offsets_q     <= '0;
			count_q       <= '0;
			calibrating_q <= 1'b0;
			calibrated_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (div_done) begin
				offsets_q <= quot;
			end
			if (pop) begin
				unique case (pop_cmd.kind)
					CMD_CAL_START: begin
						sums_q        <= '0;
						count_q       <= '0;
						calibrated_q  <= 1'b0;
						calibrating_q <= 1'b1;
					end
					CMD_FRAME: begin
						if (calibrating_q) begin
							sums_q  <= new_sums;
							count_q <= count_q + 1'b1;
							if (last) begin
								calibrating_q <= 1'b0;
								calibrated_q  <= 1'b1;
							end
						end
					end
				endcase
			end
			if (pop && is_frame) begin
				out_valid_q <= 1'b1;
			end else if (sample.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_frame) begin
			result_q.accel_x        <= pop_cmd.words[0];
			result_q.accel_y        <= pop_cmd.words[1];
			result_q.accel_z        <= pop_cmd.words[2];
			result_q.temperature    <= pop_cmd.words[3];
			result_q.rate_x         <= applied ? pop_cmd.words[4] - offsets_q[0]
			                                   : pop_cmd.words[4];
			result_q.rate_y         <= applied ? pop_cmd.words[5] - offsets_q[1]
			                                   : pop_cmd.words[5];
			result_q.rate_z         <= applied ? pop_cmd.words[6] - offsets_q[2]
			                                   : pop_cmd.words[6];
			result_q.is_calibrated  <= applied;
			result_q.in_calibration <= calibrating_q;
		end
	end

	assign sample.valid          = out_valid_q;
	assign sample.accel_x        = result_q.accel_x;
	assign sample.accel_y        = result_q.accel_y;
	assign sample.accel_z        = result_q.accel_z;
	assign sample.temperature    = result_q.temperature;
	assign sample.rate_x         = result_q.rate_x;
	assign sample.rate_y         = result_q.rate_y;
	assign sample.rate_z         = result_q.rate_z;
	assign sample.is_calibrated  = result_q.is_calibrated;
	assign sample.in_calibration = result_q.in_calibration;

endmodule

// ===== rtl/core/imu_frame_gyro_bias_removal.sv =====
// The burst channel carries one item per transfer: a burst start, a sensor byte or a
// start-calibration command. Fourteen bytes, high byte first, make one frame of three
// accelerometer words, a temperature word and three gyro words.
// The sample channel delivers one result per complete frame. The result of the
// fourteenth byte passes through the command queue and the output register; bytes are
// taken at one per cycle while the queue is not full.
// A four-entry command queue separates byte assembly from the calibration and output
// logic. When the last calibration frame is processed, the offsets are computed by a
// reciprocal multiplication over the gyro sums, which holds the queue while the divider
// is busy; the burst channel keeps taking bytes until the queue is full.
// After reset the byte position is zero, no calibration is running and the gyro words
// are passed through unchanged.
// When the receiver stalls, the current result is held in the output register, the
// queue absorbs up to four further frames or commands, and then the burst channel
// deasserts ready until space is free again.
module imu_frame_gyro_bias_removal (
	input  logic          clk,
	input  logic          arst_n,
	imu_gbr_in_if.sink    burst,
	imu_gbr_out_if.source sample
);
	import imu_gbr_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic empty;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	imu_gbr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.burst   (burst),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full)
	);

	imu_gbr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.empty   (empty)
	);

	imu_gbr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.pop_cmd(pop_cmd),
		.empty  (empty),
		.pop    (pop),
		.sample (sample)
	);

endmodule

// ===== bench/imu_gbr_frame_checker.sv =====
module imu_gbr_frame_checker (
	input  logic   clk,
	input  logic   arst_n,
	imu_gbr_in_if  burst,
	imu_gbr_out_if sample,
	output int     fail_count,
	output int     pending
);
	import imu_gbr_pkg::*;

	localparam int MAX_REPORTS = 100;

	logic [POS_W-1:0] byte_pos;
	logic [7:0]       held [HELD_BYTES];
	longint           gyro_sum [3];
	int               frames_summed;
	word_t            gyro_offset [3];
	logic             offsets_valid;
	logic             summing;
	int               fails;
	result_t          expected_samples [$];

	task automatic absorb_item(input logic [1:0] op, input logic [7:0] b);
		logic [7:0] frame [BURST_BYTES];
		word_t      words [NUM_WORDS];
		result_t    r;
		bit         took;
		bit         applied;
		took    = 1'b0;
		applied = 1'b0;
		case (op)
			OP_BURST_START: begin
				byte_pos = '0;
			end
			OP_CAL_START: begin
				for (int a = 0; a < 3; a++) gyro_sum[a] = 0;
				frames_summed = 0;
				offsets_valid = 1'b0;
				summing       = 1'b1;
			end
			OP_DATA: begin
				if (byte_pos < HELD_BYTES) begin
					held[byte_pos] = b;
					byte_pos = byte_pos + 1'b1;
				end else if (byte_pos == HELD_BYTES) begin
					byte_pos = POS_W'(BURST_BYTES);
					for (int i = 0; i < HELD_BYTES; i++) frame[i] = held[i];
					frame[HELD_BYTES] = b;
					for (int i = 0; i < NUM_WORDS; i++) words[i] = {frame[2*i], frame[2*i+1]};
					if (summing) begin
						took = 1'b1;
						for (int a = 0; a < 3; a++) gyro_sum[a] += longint'(words[4+a]);
						frames_summed++;
						if (frames_summed >= CAL_SAMPLES) begin
							for (int a = 0; a < 3; a++) begin
								gyro_offset[a] = word_t'(gyro_sum[a] / CAL_SAMPLES);
							end
							summing       = 1'b0;
							offsets_valid = 1'b1;
						end
					end else if (offsets_valid) begin
						applied = 1'b1;
					end
					r.accel_x        = words[0];
					r.accel_y        = words[1];
					r.accel_z        = words[2];
					r.temperature    = words[3];
					r.rate_x         = applied ? word_t'(words[4] - gyro_offset[0]) : words[4];
					r.rate_y         = applied ? word_t'(words[5] - gyro_offset[1]) : words[5];
					r.rate_z         = applied ? word_t'(words[6] - gyro_offset[2]) : words[6];
					r.is_calibrated  = applied;
					r.in_calibration = took;
					expected_samples.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fails++;
			if (fails <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
					$signed(want), $signed(got));
			end
		end
	endtask

	task automatic check_sample();
		result_t want;
		result_t got;
		got.accel_x        = sample.accel_x;
		got.accel_y        = sample.accel_y;
		got.accel_z        = sample.accel_z;
		got.temperature    = sample.temperature;
		got.rate_x         = sample.rate_x;
		got.rate_y         = sample.rate_y;
		got.rate_z         = sample.rate_z;
		got.is_calibrated  = sample.is_calibrated;
		got.in_calibration = sample.in_calibration;
		if (expected_samples.size() == 0) begin
			fails++;
			if (fails <= MAX_REPORTS) begin
				$display("%0t: unexpected sample, expected none, actual %h", $time, got);
			end
		end else begin
			want = expected_samples.pop_front();
			compare_field("accel_x", want.accel_x, got.accel_x);
			compare_field("accel_y", want.accel_y, got.accel_y);
			compare_field("accel_z", want.accel_z, got.accel_z);
			compare_field("temperature", want.temperature, got.temperature);
			compare_field("rate_x", want.rate_x, got.rate_x);
			compare_field("rate_y", want.rate_y, got.rate_y);
			compare_field("rate_z", want.rate_z, got.rate_z);
			compare_field("is_calibrated", {15'd0, want.is_calibrated}, {15'd0, got.is_calibrated});
			compare_field("in_calibration", {15'd0, want.in_calibration},
				{15'd0, got.in_calibration});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos      = '0;
			frames_summed = 0;
			offsets_valid = 1'b0;
			summing       = 1'b0;
			for (int a = 0; a < 3; a++) begin
				gyro_sum[a]    = 0;
				gyro_offset[a] = '0;
			end
			expected_samples.delete();
			fails = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (burst.valid && burst.ready) absorb_item(burst.opcode, burst.data_byte);
			if (sample.valid && sample.ready) check_sample();
			pending    <= expected_samples.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== bench/tb.sv =====
module tb;
	import imu_gbr_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;

	logic clk;
	logic arst_n;
	int   cycle_no = 0;
	int   calm_src = 0;
	int   items_offered = 0;
	int   gyro_bias [3];
	int   chk_fail;
	int   chk_pending;

	imu_gbr_in_if  burst_ch ();
	imu_gbr_out_if sample_ch ();

	imu_frame_gyro_bias_removal dut (
		.clk    (clk),
		.arst_n (arst_n),
		.burst  (burst_ch),
		.sample (sample_ch)
	);

	imu_gbr_frame_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst      (burst_ch),
		.sample     (sample_ch),
		.fail_count (chk_fail),
		.pending    (chk_pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	initial begin
		#80000000;
		$display("status: fail");
		$finish;
	end

	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 999);
		if (r < 3) begin
			calm = $urandom_range(100, 400);
			return 0;
		end
		if (r < 650) return 0;
		if (r < 960) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic word_t rand_word();
		int r;
		r = $urandom_range(0, 7);
		case (r)
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			default: return word_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// The receiver is held off twice for a long stretch so that the block fills up.
	initial begin : sink_pacing
		int gap_left;
		int hold_left;
		int calm_snk;
		gap_left  = 0;
		hold_left = 0;
		calm_snk  = 0;
		sample_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (cycle_no == 300 || cycle_no == 1500) hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				sample_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				sample_ch.ready <= 1'b0;
			end else begin
				sample_ch.ready <= 1'b1;
				gap_left = idle_len(calm_snk);
			end
		end
	end

	task automatic offer_item(input logic [1:0] op, input logic [7:0] b);
		int gap;
		gap = idle_len(calm_src);
		if (gap > 0) begin
			burst_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_ch.valid     <= 1'b1;
		burst_ch.opcode    <= op;
		burst_ch.data_byte <= b;
		@(posedge clk);
		while (!burst_ch.ready) @(posedge clk);
		items_offered++;
	endtask

	task automatic offer_frame(input word_t w [NUM_WORDS], input bit with_start);
		if (with_start) offer_item(OP_BURST_START, 8'($urandom_range(0, 255)));
		for (int i = 0; i < NUM_WORDS; i++) begin
			offer_item(OP_DATA, w[i][15:8]);
			offer_item(OP_DATA, w[i][7:0]);
		end
	endtask

	task automatic offer_cal_frames(input int n, input bit extremes);
		word_t w [NUM_WORDS];
		for (int f = 0; f < n; f++) begin
			for (int k = 0; k < 4; k++) w[k] = rand_word();
			if (extremes) begin
				w[4] = 16'sh8000;
				w[5] = word_t'(int'($urandom_range(0, 5)) - 3);
				w[6] = 16'sh7fff;
			end else begin
				for (int a = 0; a < 3; a++) begin
					w[4+a] = word_t'(gyro_bias[a] + int'($urandom_range(0, 128)) - 64);
				end
			end
			offer_frame(w, 1'b1);
		end
	endtask

	task automatic random_traffic(input int target);
		int    first;
		int    r;
		int    n;
		word_t w [NUM_WORDS];
		first = items_offered;
		while (items_offered - first < target) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				for (int k = 0; k < NUM_WORDS; k++) w[k] = rand_word();
				offer_frame(w, 1'b1);
				if (r < 8) begin
					n = $urandom_range(1, 3);
					repeat (n) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
				end
			end else if (r < 88) begin
				offer_item(OP_BURST_START, 8'($urandom_range(0, 255)));
				n = $urandom_range(1, HELD_BYTES);
				repeat (n) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
			end else if (r < 93) begin
				offer_item(OP_RESERVED, 8'($urandom_range(0, 255)));
			end else if (r < 97) begin
				n = $urandom_range(1, BURST_BYTES);
				repeat (n) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
			end else begin
				offer_item(OP_BURST_START, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin : stimulus
		word_t edge_words [NUM_WORDS];
		int    waited;
		arst_n             = 1'b0;
		burst_ch.valid     = 1'b0;
		burst_ch.opcode    = OP_BURST_START;
		burst_ch.data_byte = 8'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// A burst straight after reset needs no burst start.
		edge_words[0] = 16'sh8000;
		edge_words[1] = 16'sh7fff;
		edge_words[2] = 16'sh0000;
		edge_words[3] = -16'sd1;
		edge_words[4] = 16'sh8000;
		edge_words[5] = 16'sh7fff;
		edge_words[6] = 16'sh00ff;
		offer_frame(edge_words, 1'b0);
		offer_item(OP_DATA, 8'hff);
		offer_item(OP_RESERVED, 8'ha5);
		offer_item(OP_BURST_START, 8'h00);
		repeat (3) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
		offer_item(OP_BURST_START, 8'hff);

		for (int a = 0; a < 3; a++) gyro_bias[a] = int'($urandom_range(0, 6000)) - 3000;
		offer_item(OP_CAL_START, 8'($urandom_range(0, 255)));
		offer_cal_frames(20, 1'b0);

		// Calibration restarted in the middle of a burst; the burst carries on.
		offer_item(OP_BURST_START, 8'($urandom_range(0, 255)));
		repeat (6) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
		offer_item(OP_CAL_START, 8'($urandom_range(0, 255)));
		repeat (8) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
		offer_cal_frames(20, 1'b1);

		random_traffic(560);

		burst_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		waited = 0;
		while (chk_pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (64) @(posedge clk);
		if (chk_fail == 0 && chk_pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/imu_gbr_pkg.sv
rtl/core/imu_gbr_in_if.sv
rtl/core/imu_gbr_out_if.sv
rtl/core/imu_gbr_front.sv
rtl/core/imu_gbr_fifo.sv
rtl/core/imu_gbr_div.sv
rtl/core/imu_gbr_back.sv
rtl/core/imu_frame_gyro_bias_removal.sv
bench/imu_gbr_frame_checker.sv
bench/tb.sv
